/* hdl/psched_pkg.sv */
// Shared types and codes for the process scheduler.
`timescale 1ns / 1ps

package psched_pkg;

  // One queue entry as held in a cell.
  typedef struct packed {
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [15:0]       rt;
    logic [15:0]       used;
  } slot_t;

  // Best entry seen so far, travelling down the cell chain.
  typedef struct packed {
    logic  vld;
    slot_t s;
  } cand_t;

  // Commands broadcast to every cell in the commit cycle.
  typedef struct packed {
    logic rm;
    logic wr;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam logic       MODE_ADD      = 1'b0;
  localparam logic       MODE_DISPATCH = 1'b1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_SJF  = 2'd3;

  localparam logic [1:0] STATUS_ADDED = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RUN   = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  localparam logic signed [7:0] PRIO_MIN  = -8'sd128;
  localparam logic [15:0]       USED_MAX  = 16'hFFFF;

endpackage

/* hdl/psched_intf.sv */
// Handshake channel interfaces of the process scheduler.
`timescale 1ns / 1ps

interface psched_item_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [7:0]        proc_id;
  logic signed [7:0] new_priority;
  logic [15:0]       new_runtime;

  modport source (output valid, mode, proc_id, new_priority, new_runtime, input ready);
  modport sink   (input valid, mode, proc_id, new_priority, new_runtime, output ready);
endinterface

interface psched_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [7:0]        run_id;
  logic signed [7:0] run_priority;
  logic [15:0]       run_runtime;
  logic [15:0]       used_time;
  logic              finished;
  logic [31:0]       start_time;
  logic [31:0]       end_time;

  modport source (output valid, status, run_id, run_priority, run_runtime, used_time,
                  finished, start_time, end_time, input ready);
  modport sink   (input valid, status, run_id, run_priority, run_runtime, used_time,
                  finished, start_time, end_time, output ready);
endinterface

interface psched_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/process_scheduler_fifo_rr_prio_sjf_top.sv */
// Top level of the ready-queue process scheduler.
`timescale 1ns / 1ps

// Ready-queue scheduler with FIFO, round robin, priority and shortest-job-first
// dispatch. The queue lives in a row of QUEUE_DEPTH cells, head in cell 0. A
// best-candidate record walks down the row, one cell per clock, so a dispatch
// request on a non-empty queue goes from acceptance through the scan state,
// whose length the candidate chain sets, to the done state, where its result
// is committed once the output register is free or being read; an add
// request or a dispatch on an empty queue goes straight to the done state.
// One request is in work at a time; a finished result sits in an output
// register, so the next request is accepted while that result waits.
// There is no clearing pass after reset. Write the policy
// register only while no request is in work.
module process_scheduler_fifo_rr_prio_sjf_top
  import psched_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  psched_cfg_if.sink       cfg_i,
  psched_item_if.sink      items_i,
  psched_result_if.source  results_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] CountFull = CW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] ScanLast  = IW'(QUEUE_DEPTH - 1);

  state_e state_q, state_d;
  logic [IW-1:0] scan_q;
  logic [CW-1:0] count_q;
  logic [31:0]   time_q;
  logic [1:0]    policy_q;

  // Request held while in work.
  logic              mode_q;
  slot_t             req_q;

  // Output register.
  logic              out_vld_q;
  logic [1:0]        o_status_q;
  slot_t             o_slot_q;
  logic              o_fin_q;
  logic [31:0]       o_t0_q, o_t1_q;

  // Cell row.
  slot_t         slot_w   [QUEUE_DEPTH];
  cand_t         cand_w   [QUEUE_DEPTH];
  logic [IW-1:0] cidx_w   [QUEUE_DEPTH];
  cell_cmd_t     cmd;
  logic [IW-1:0] wr_idx;
  slot_t         wr_slot;

  // Commit-cycle results.
  logic          commit;
  logic          full, empty;
  cand_t         best;
  logic [IW-1:0] sel;
  logic          to_end;
  logic [15:0]   rem, used_inc, used_new;
  logic          fin;
  logic signed [7:0] prio_nxt;
  logic [31:0]   t1;
  logic [1:0]    status;

  assign cfg_i.ready   = 1'b1;
  assign items_i.ready = (state_q == ST_IDLE);

  assign full   = (count_q == CountFull);
  assign empty  = (count_q == '0);
  assign commit = (state_q == ST_DONE) && (!out_vld_q || results_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (items_i.valid) begin
          state_d = (items_i.mode == MODE_DISPATCH && !empty) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_q == ScanLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Dispatch arithmetic on the candidate leaving the last cell.
  always_comb begin
    best     = cand_w[QUEUE_DEPTH-1];
    sel      = cidx_w[QUEUE_DEPTH-1];
    to_end   = (policy_q == POL_FIFO) || (policy_q == POL_SJF);
    rem      = (best.s.used < best.s.rt) ? (best.s.rt - best.s.used) : 16'd0;
    used_inc = (best.s.used != USED_MAX) ? (best.s.used + 16'd1) : best.s.used;
    used_new = to_end ? best.s.rt : used_inc;
    fin      = to_end || (used_inc >= best.s.rt);
    prio_nxt = (policy_q == POL_PRIO && best.s.prio != PRIO_MIN) ?
               (best.s.prio - 8'sd1) : best.s.prio;
    t1       = time_q + (to_end ? {16'd0, rem} : 32'd1);
  end

  // Outputs of the commit cycle: cell commands and result status.
  always_comb begin
    cmd     = '0;
    wr_idx  = count_q[IW-1:0];
    wr_slot = req_q;
    status  = STATUS_ADDED;
    if (mode_q == MODE_ADD) begin
      status = full ? STATUS_FULL : STATUS_ADDED;
      cmd.wr = commit && !full;
    end else if (empty) begin
      status = STATUS_EMPTY;
    end else begin
      status  = STATUS_RUN;
      cmd.rm  = commit;
      // Put an unfinished process back at the new tail.
      cmd.wr  = commit && !fin;
      wr_idx  = IW'(count_q - CW'(1));
      wr_slot = '{id: best.s.id, prio: prio_nxt, rt: best.s.rt, used: used_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      count_q   <= '0;
      time_q    <= '0;
      policy_q  <= POL_FIFO;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        policy_q <= cfg_i.data;
      end
      // Advance the scan counter only while the candidate settles.
      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + IW'(1);
      end else begin
        scan_q <= '0;
      end
      if (commit) begin
        out_vld_q <= 1'b1;
        if (mode_q == MODE_ADD) begin
          if (!full) begin
            count_q <= count_q + CW'(1);
          end
        end else if (!empty) begin
          time_q <= t1;
          if (fin) begin
            count_q <= count_q - CW'(1);
          end
        end
      end else if (results_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the request payload and load the result payload.
  always_ff @(posedge clk_i) begin
    if (items_i.valid && items_i.ready) begin
      mode_q <= items_i.mode;
      req_q  <= '{id: items_i.proc_id, prio: items_i.new_priority,
                  rt: items_i.new_runtime, used: 16'd0};
    end
    if (commit) begin
      o_status_q <= status;
      if (status == STATUS_RUN) begin
        o_slot_q <= '{id: best.s.id, prio: best.s.prio, rt: best.s.rt, used: used_new};
        o_fin_q  <= fin;
        o_t0_q   <= time_q;
        o_t1_q   <= t1;
      end else begin
        o_slot_q <= '0;
        o_fin_q  <= 1'b0;
        o_t0_q   <= '0;
        o_t1_q   <= '0;
      end
    end
  end

  assign results_o.valid        = out_vld_q;
  assign results_o.status       = o_status_q;
  assign results_o.run_id       = o_slot_q.id;
  assign results_o.run_priority = o_slot_q.prio;
  assign results_o.run_runtime  = o_slot_q.rt;
  assign results_o.used_time    = o_slot_q.used;
  assign results_o.finished     = o_fin_q;
  assign results_o.start_time   = o_t0_q;
  assign results_o.end_time     = o_t1_q;

  // Row of cells: data shifts toward the head, candidates toward the tail.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t         nxt_slot;
    cand_t         cand_in;
    logic [IW-1:0] cidx_in;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_slot = slot_w[i];
    end else begin : g_mid
      assign nxt_slot = slot_w[i+1];
    end

    if (i == 0) begin : g_head
      assign cand_in = '0;
      assign cidx_in = '0;
    end else begin : g_rest
      assign cand_in = cand_w[i-1];
      assign cidx_in = cidx_w[i-1];
    end

    psched_cell #(
      .Depth (QUEUE_DEPTH),
      .Idx   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .sel_i      (sel),
      .wr_idx_i   (wr_idx),
      .count_i    (count_q),
      .policy_i   (policy_q),
      .wr_slot_i  (wr_slot),
      .nxt_slot_i (nxt_slot),
      .slot_o     (slot_w[i]),
      .cand_i     (cand_in),
      .cand_idx_i (cidx_in),
      .cand_o     (cand_w[i]),
      .cand_idx_o (cidx_w[i])
    );
  end

  // The queue never holds more entries than there are cells.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("queue count beyond depth");

  // Queue size changes only in a commit cycle.
  a_count_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(commit))
    else $error("queue count changed outside commit");

  // A dispatch on a non-empty queue always finds a candidate inside the queue.
  a_cand_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && mode_q == MODE_DISPATCH && !empty) |->
      (best.vld && (CW'(sel) < count_q)))
    else $error("no valid candidate at dispatch");

  // A scan always runs its counter to the last cell of the chain.
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && $past(state_q) == ST_SCAN) |-> ($past(scan_q) == ScanLast))
    else $error("scan ended early");

endmodule

/* hdl/psched_cell.sv */
// One queue slot with its stage of the selection chain.
`timescale 1ns / 1ps

module psched_cell
  import psched_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned Idx   = 0,
  localparam int unsigned IW   = $clog2(Depth),
  localparam int unsigned CW   = $clog2(Depth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_cmd_t     cmd_i,
  input  logic [IW-1:0] sel_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [CW-1:0] count_i,
  input  logic [1:0]    policy_i,
  input  slot_t         wr_slot_i,
  input  slot_t         nxt_slot_i,
  output slot_t         slot_o,
  input  cand_t         cand_i,
  input  logic [IW-1:0] cand_idx_i,
  output cand_t         cand_o,
  output logic [IW-1:0] cand_idx_o
);

  localparam logic [IW-1:0] MyIdx = IW'(Idx);

  slot_t         slot_q;
  cand_t         cand_q, cand_d;
  logic [IW-1:0] cidx_q, cidx_d;
  logic          own_vld;
  logic          take_own;

  assign own_vld = (CW'(Idx) < count_i);

  // First entry wins ties: take own entry only when strictly better.
  always_comb begin
    take_own = 1'b0;
    if (own_vld) begin
      if (!cand_i.vld) begin
        take_own = 1'b1;
      end else begin
        unique case (policy_i)
          POL_PRIO: take_own = (slot_q.prio > cand_i.s.prio);
          POL_SJF:  take_own = (slot_q.rt < cand_i.s.rt);
          default:  take_own = 1'b0;
        endcase
      end
    end
    if (take_own) begin
      cand_d = '{vld: 1'b1, s: slot_q};
      cidx_d = MyIdx;
    end else begin
      cand_d = cand_i;
      cidx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      cidx_q <= '0;
    end else begin
      cand_q <= cand_d;
      cidx_q <= cidx_d;
    end
  end

  // Append wins over the compaction shift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (wr_idx_i == MyIdx)) begin
      slot_q <= wr_slot_i;
    end else if (cmd_i.rm && (MyIdx >= sel_i)) begin
      slot_q <= nxt_slot_i;
    end
  end

  assign slot_o     = slot_q;
  assign cand_o     = cand_q;
  assign cand_idx_o = cidx_q;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the ready-queue process scheduler.
`timescale 1ns / 1ps

module tb_top;
  import psched_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  // One scheduler answer, field for field as the result channel carries it.
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [15:0]       rt;
    logic [15:0]       used;
    logic              fin;
    logic [31:0]       t_start;
    logic [31:0]       t_end;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  psched_cfg_if    cfg_ch();
  psched_item_if   item_ch();
  psched_result_if res_ch();

  process_scheduler_fifo_rr_prio_sjf_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .items_i  (item_ch),
    .results_o(res_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the ready queue, head at index 0, plus the scheduler clock.
  logic [7:0]        rq_id   [QDEPTH];
  logic signed [7:0] rq_prio [QDEPTH];
  logic [15:0]       rq_rt   [QDEPTH];
  logic [15:0]       rq_used [QDEPTH];
  int                rq_len;
  logic [31:0]       sched_clock;
  logic [1:0]        active_policy;

  sched_result_t due_results[$];
  int            error_count;
  int unsigned   cycle_count = 0;

  // Sender burst shaping and receiver hold-off request.
  int burst_left;
  bit sender_gaps;
  int result_hold_req;

  // Apply one request to the mirrored queue and work out the answer it earns.
  task automatic schedule_request(input logic mode, input logic [7:0] id,
                                  input logic signed [7:0] prio,
                                  input logic [15:0] rt,
                                  output sched_result_t r);
    int                pick;
    logic [7:0]        c_id;
    logic signed [7:0] c_prio;
    logic [15:0]       c_rt;
    logic [15:0]       c_used;
    logic [15:0]       remain;
    logic              done;
    r = '0;
    if (mode == MODE_ADD) begin
      if (rq_len >= QDEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        rq_id[rq_len]   = id;
        rq_prio[rq_len] = prio;
        rq_rt[rq_len]   = rt;
        rq_used[rq_len] = 16'd0;
        rq_len++;
        r.status = STATUS_ADDED;
      end
      return;
    end
    if (rq_len == 0) begin
      r.status = STATUS_EMPTY;
      return;
    end
    // First entry wins ties: only a strictly better one moves the pick.
    pick = 0;
    for (int i = 1; i < rq_len; i++) begin
      if (active_policy == POL_PRIO && rq_prio[i] > rq_prio[pick]) pick = i;
      if (active_policy == POL_SJF && rq_rt[i] < rq_rt[pick]) pick = i;
    end
    c_id   = rq_id[pick];
    c_prio = rq_prio[pick];
    c_rt   = rq_rt[pick];
    c_used = rq_used[pick];
    for (int i = pick; i + 1 < rq_len; i++) begin
      rq_id[i]   = rq_id[i + 1];
      rq_prio[i] = rq_prio[i + 1];
      rq_rt[i]   = rq_rt[i + 1];
      rq_used[i] = rq_used[i + 1];
    end
    rq_len--;
    r.t_start = sched_clock;
    if (active_policy == POL_FIFO || active_policy == POL_SJF) begin
      remain      = (c_used < c_rt) ? c_rt - c_used : 16'd0;
      sched_clock = sched_clock + {16'd0, remain};
      c_used      = c_rt;
      done        = 1'b1;
    end else begin
      if (c_used != USED_MAX) c_used = c_used + 16'd1;
      sched_clock = sched_clock + 32'd1;
      done        = (c_used >= c_rt);
      if (!done) begin
        rq_id[rq_len]   = c_id;
        rq_prio[rq_len] = (active_policy == POL_PRIO && c_prio != PRIO_MIN) ?
                          c_prio - 8'sd1 : c_prio;
        rq_rt[rq_len]   = c_rt;
        rq_used[rq_len] = c_used;
        rq_len++;
      end
    end
    r.status = STATUS_RUN;
    r.id     = c_id;
    r.prio   = c_prio;
    r.rt     = c_rt;
    r.used   = c_used;
    r.fin    = done;
    r.t_end  = sched_clock;
  endtask

  function automatic string show_result(sched_result_t r);
    return $sformatf("status=%0d id=%0d prio=%0d rt=%0d used=%0d fin=%0d start=%0d end=%0d",
                     r.status, r.id, r.prio, r.rt, r.used, r.fin, r.t_start, r.t_end);
  endfunction

  // Offer one request, record its answer once accepted, then maybe pause
  // at the end of a burst. Valid stays high when the burst goes on.
  task automatic send_request(input logic mode, input logic [7:0] id,
                              input logic signed [7:0] prio, input logic [15:0] rt);
    sched_result_t r;
    int            gap;
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= mode;
    item_ch.proc_id      <= id;
    item_ch.new_priority <= prio;
    item_ch.new_runtime  <= rt;
    do @(posedge clk_i); while (!item_ch.ready);
    schedule_request(mode, id, prio, rt, r);
    due_results.push_back(r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_gaps) begin
        gap = $urandom_range(1, 12);
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Random request: add or dispatch, mixed at the given add percentage, with fields biased toward
  // ties, the priority floor and runtimes short enough to finish.
  task automatic send_random_request(input int add_pct);
    logic              mode;
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [15:0]       rt;
    mode = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_DISPATCH;
    id   = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0, 1:    prio = 8'($urandom_range(0, 255));
      2, 3:    prio = 8'($urandom_range(0, 4) - 2);
      4:       prio = 8'(PRIO_MIN + $urandom_range(0, 2));
      default: prio = 8'(8'sd127 - $urandom_range(0, 1));
    endcase
    case ($urandom_range(0, 9))
      6, 7:    rt = 16'($urandom_range(7, 40));
      8:       rt = USED_MAX;
      9:       rt = 16'($urandom_range(0, 65535));
      default: rt = 16'($urandom_range(0, 6));
    endcase
    send_request(mode, id, prio, rt);
  endtask

  // Drop valid and hold until every answer owed has come back.
  task automatic wait_results_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // The block is idle once drained: each request earns exactly one answer.
  task automatic write_policy(input logic [1:0] pol);
    wait_results_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= pol;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    active_policy = pol;
  endtask

  // Dispatch on an empty queue right after reset.
  task automatic test_empty_dispatch();
    send_request(MODE_DISPATCH, 8'h00, 8'sd0, 16'd0);
  endtask

  // Fill every slot with field extremes, then overflow it once.
  task automatic test_fill_and_overflow();
    logic [15:0] rt;
    write_policy(POL_SJF);
    for (int k = 0; k < QDEPTH; k++) begin
      rt = (k == 15) ? USED_MAX : (k == 7) ? 16'd0 : 16'(k + 2);
      send_request(MODE_ADD, 8'(k * 17), 8'(k * 17 - 128), rt);
    end
    send_request(MODE_ADD, 8'h5A, -8'sd1, 16'h00FF);
  endtask

  // One dispatch or two under each policy, starting from the full queue.
  task automatic test_policy_selection();
    send_request(MODE_DISPATCH, 8'hFF, 8'sd127, 16'hFFFF);
    write_policy(POL_PRIO);
    send_request(MODE_DISPATCH, 8'h00, -8'sd128, 16'h0000);
    send_request(MODE_DISPATCH, 8'hA5, 8'sd90, 16'h5A5A);
    write_policy(POL_RR);
    send_request(MODE_DISPATCH, 8'h5A, -8'sd90, 16'hA5A5);
    write_policy(POL_FIFO);
    send_request(MODE_DISPATCH, 8'h33, 8'sd3, 16'h0003);
  endtask

  // Stall the result side for a long stretch while requests keep coming,
  // so the block fills and pushes back on its input.
  task automatic test_backpressure();
    wait_results_drained();
    sender_gaps     = 1'b0;
    result_hold_req = 400;
    repeat (40) send_random_request(50);
    sender_gaps = 1'b1;
  endtask

  // Random phases: every policy in turn first, then at random, each with
  // its own add mix so the queue swings between full and empty.
  task automatic test_random_mix();
    int sent;
    int phase;
    int n;
    int add_pct;
    sent  = 0;
    phase = 0;
    while (sent < 840) begin
      write_policy((phase < 8) ? 2'(phase % 4) : 2'($urandom_range(0, 3)));
      n = $urandom_range(40, 100);
      case ($urandom_range(0, 2))
        0:       add_pct = 25;
        1:       add_pct = 50;
        default: add_pct = 75;
      endcase
      sender_gaps = ($urandom_range(0, 3) != 0);
      repeat (n) send_random_request(add_pct);
      sent += n;
      phase++;
    end
  endtask

  // Compare each accepted answer with the oldest one owed.
  sched_result_t got_result;
  sched_result_t want_result;
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got_result.status  = res_ch.status;
      got_result.id      = res_ch.run_id;
      got_result.prio    = res_ch.run_priority;
      got_result.rt      = res_ch.run_runtime;
      got_result.used    = res_ch.used_time;
      got_result.fin     = res_ch.finished;
      got_result.t_start = res_ch.start_time;
      got_result.t_end   = res_ch.end_time;
      if (due_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: %s", show_result(got_result));
      end else begin
        want_result = due_results.pop_front();
        if (got_result.status !== want_result.status || got_result.id !== want_result.id ||
            got_result.prio !== want_result.prio || got_result.rt !== want_result.rt ||
            got_result.used !== want_result.used || got_result.fin !== want_result.fin ||
            got_result.t_start !== want_result.t_start ||
            got_result.t_end !== want_result.t_end) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch expected: %s", show_result(want_result));
            $display("mismatch actual:   %s", show_result(got_result));
          end
        end
      end
    end
  end

  // Result side: stall in a style drawn at random and redrawn when its run is
  // over, and honor a long hold-off when one is requested.
  initial begin
    int hold_left;
    int style;
    int style_left;
    hold_left    = 0;
    style        = 0;
    style_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_hold_req != 0) begin
        hold_left       = result_hold_req;
        result_hold_req = 0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(150, 400);
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (style)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= 1'($urandom_range(0, 1));
          2:       res_ch.ready <= (style_left % 4 == 0);
          default: res_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = POL_FIFO;
    item_ch.valid        = 1'b0;
    item_ch.mode         = MODE_ADD;
    item_ch.proc_id      = 8'h00;
    item_ch.new_priority = 8'sd0;
    item_ch.new_runtime  = 16'd0;
    rq_len               = 0;
    sched_clock          = 32'd0;
    active_policy        = POL_FIFO;
    error_count          = 0;
    burst_left           = 1;
    sender_gaps          = 1'b1;
    result_hold_req      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dispatch();
    test_fill_and_overflow();
    test_policy_selection();
    test_backpressure();
    test_random_mix();

    // Let owed answers come in, then watch a little longer for strays.
    wait_results_drained();
    repeat (QDEPTH + 8) @(posedge clk_i);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* process_scheduler_fifo_rr_prio_sjf_top.f */
hdl/psched_pkg.sv
hdl/psched_intf.sv
hdl/psched_cell.sv
hdl/process_scheduler_fifo_rr_prio_sjf_top.sv
dv/tb_top.sv
